FILE: rtl/bsu_pkg.sv
// Shared types, codes and constants for the barrier synchronization unit.
package bsu_pkg;

    localparam int ADDR_W = 64;
    localparam int TID_W  = 6;
    localparam int CNT_W  = 7;

    localparam int DEF_BARRIER_SLOTS = 16;
    localparam int DEF_THREAD_SLOTS  = 64;

    typedef enum logic [0:0] {
        CMD_DEFINE = 1'b0,
        CMD_WAIT   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_DEFINED = 3'd0,
        KIND_ALREADY = 3'd1,
        KIND_SLEEP   = 3'd2,
        KIND_WAKE    = 3'd3,
        KIND_UNKNOWN = 3'd4,
        KIND_FULL    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_WAKE
    } state_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic look;       // capture hit and free grant
        logic wr_define;  // granted cell installs the command's barrier
        logic wr_wait;    // hit cell updates its waiter set
        logic clear_set;  // with wr_wait: barrier released, set goes empty
    } bsu_ctrl_t;

endpackage

FILE: rtl/bsu_if.sv
// Valid/ready channel interfaces for commands and results.
interface bsu_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [bsu_pkg::TID_W-1:0]   thread;
    logic [bsu_pkg::ADDR_W-1:0]  address;
    logic [bsu_pkg::CNT_W-1:0]   thread_count;

    modport source (output valid, cmd, thread, address, thread_count,
                    input ready);
    modport sink   (input valid, cmd, thread, address, thread_count,
                    output ready);
endinterface

interface bsu_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  kind;
    logic [bsu_pkg::TID_W-1:0]   thread_out;
    logic                        last;

    modport source (output valid, kind, thread_out, last, input ready);
    modport sink   (input valid, kind, thread_out, last, output ready);
endinterface

FILE: rtl/bsu_cell.sv
// One barrier table slot: address, target, waiter set and its link in the chain.
module bsu_cell #(
    parameter int THREAD_SLOTS = bsu_pkg::DEF_THREAD_SLOTS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsu_pkg::bsu_ctrl_t           ctrl,
    input  logic [bsu_pkg::ADDR_W-1:0]   cmd_addr,
    input  logic [bsu_pkg::CNT_W-1:0]    cmd_target,
    input  logic [THREAD_SLOTS-1:0]      cmd_bit,
    input  logic [THREAD_SLOTS-1:0]      new_mask,
    input  logic                         free_in,
    output logic                         free_out,
    input  logic                         hit_in,
    output logic                         hit_out,
    input  logic [THREAD_SLOTS-1:0]      mask_in,
    output logic [THREAD_SLOTS-1:0]      mask_out,
    input  logic [bsu_pkg::CNT_W-1:0]    target_in,
    output logic [bsu_pkg::CNT_W-1:0]    target_out,
    output logic                         hit_q
);
    import bsu_pkg::*;

    logic                    valid_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [CNT_W-1:0]        target_reg;
    logic [THREAD_SLOTS-1:0] waiter_reg;
    logic                    hit_reg;
    logic                    grant_reg;

    logic hit;
    logic grant;

    assign hit   = valid_reg && (addr_reg == cmd_addr);
    // lowest free slot wins: no free slot upstream and this one empty
    assign grant = !valid_reg && !free_in;

    assign free_out   = free_in | !valid_reg;
    assign hit_out    = hit_in | hit;
    assign mask_out   = mask_in | (hit ? (waiter_reg | cmd_bit) : '0);
    assign target_out = target_in | (hit ? target_reg : '0);
    assign hit_q      = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            waiter_reg <= '0;
            hit_reg    <= 1'b0;
            grant_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.look)
            begin
                hit_reg   <= hit;
                grant_reg <= grant;
            end
            if (ctrl.wr_define && grant_reg)
            begin
                valid_reg  <= 1'b1;
                waiter_reg <= '0;
            end
            else if (ctrl.wr_wait && hit_reg)
            begin
                waiter_reg <= ctrl.clear_set ? '0 : new_mask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_define && grant_reg)
        begin
            addr_reg   <= cmd_addr;
            target_reg <= cmd_target;
        end
    end

    // a captured grant means the slot was empty, so it cannot also hit
    assert property (@(posedge clk) disable iff (!rst_n) !(hit_reg && grant_reg))
        else $error("cell both hit and granted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_define && grant_reg) |=> (valid_reg && waiter_reg == '0))
        else $error("define did not install an empty entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_wait && ctrl.clear_set && hit_reg) |=> (waiter_reg == '0))
        else $error("released barrier kept waiters");

endmodule

FILE: rtl/barrier_sync_unit.sv
// Barrier synchronization unit: top level with command sequencer and cell chain.
//
// A table of BARRIER_SLOTS counting barriers, keyed by 64-bit address, held
// in a row of cells. Each cell compares its address against the command in
// parallel; a free-slot chain running from cell 0 upward grants a define to
// the lowest empty slot, and the hit cell hands its updated waiter set and
// target down the chain to the sequencer. A define or a wait that does not
// release its barrier passes through accept, chain lookup and execute
// before the next ready. A wait that releases a barrier with N waiters
// then drains them in a wake burst: wake transactions come out one per
// cycle while the output register has room, lowest thread first, from a
// priority encoder over the released set, with last set on the final one.
// The result sits in an output register, so a new command is
// taken while the previous result is still waiting to be taken; the unit
// stalls in execute or wake only while that register is full. Threads at or
// above THREAD_SLOTS and waits on unknown addresses report unknown barrier;
// a target of zero or above THREAD_SLOTS is never reached. Entries are
// never removed. No clearing pass: the unit is ready right after reset.
module barrier_sync_unit #(
    parameter int BARRIER_SLOTS = bsu_pkg::DEF_BARRIER_SLOTS,
    parameter int THREAD_SLOTS  = bsu_pkg::DEF_THREAD_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    bsu_in_if.sink      in_ch,
    bsu_out_if.source   out_ch
);
    import bsu_pkg::*;

    // ---------------------------------------------------------------
    // Command capture
    // ---------------------------------------------------------------
    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg;
    logic [TID_W-1:0]        tid_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [CNT_W-1:0]        count_reg;

    // lookup results captured at the end of the chain
    logic                    hit_any_reg;
    logic                    free_any_reg;
    logic [THREAD_SLOTS-1:0] mask_reg;
    logic [CNT_W-1:0]        tgt_reg;

    // wake burst
    logic [THREAD_SLOTS-1:0] wake_reg, wake_next;

    // output register
    logic                    ovalid_reg, ovalid_next;
    kind_t                   okind_reg, okind_next;
    logic [TID_W-1:0]        othread_reg, othread_next;
    logic                    olast_reg, olast_next;

    logic                    in_fire;
    logic                    out_free;
    logic                    emit;
    bsu_ctrl_t               ctrl;

    logic                    tid_ok;
    logic [THREAD_SLOTS-1:0] cmd_bit;
    logic [CNT_W-1:0]        pop;
    logic                    reached;
    logic [TID_W-1:0]        wake_idx;
    logic [THREAD_SLOTS-1:0] wake_rest;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    logic                    free_c   [0:BARRIER_SLOTS];
    logic                    hit_c    [0:BARRIER_SLOTS];
    logic [THREAD_SLOTS-1:0] mask_c   [0:BARRIER_SLOTS];
    logic [CNT_W-1:0]        target_c [0:BARRIER_SLOTS];
    logic [BARRIER_SLOTS-1:0] hit_vec;

    assign free_c[0]   = 1'b0;
    assign hit_c[0]    = 1'b0;
    assign mask_c[0]   = '0;
    assign target_c[0] = '0;

    for (genvar g = 0; g < BARRIER_SLOTS; g++)
    begin : g_cell
        bsu_cell #(
            .THREAD_SLOTS (THREAD_SLOTS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmd_addr   (addr_reg),
            .cmd_target (count_reg),
            .cmd_bit    (cmd_bit),
            .new_mask   (mask_reg),
            .free_in    (free_c[g]),
            .free_out   (free_c[g+1]),
            .hit_in     (hit_c[g]),
            .hit_out    (hit_c[g+1]),
            .mask_in    (mask_c[g]),
            .mask_out   (mask_c[g+1]),
            .target_in  (target_c[g]),
            .target_out (target_c[g+1]),
            .hit_q      (hit_vec[g])
        );
    end

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    function automatic logic [CNT_W-1:0] pop_count(input logic [THREAD_SLOTS-1:0] m);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < THREAD_SLOTS; i++)
        begin
            n = n + CNT_W'(m[i]);
        end
        return n;
    endfunction

    function automatic logic [TID_W-1:0] lowest_set(input logic [THREAD_SLOTS-1:0] m);
        logic [TID_W-1:0] idx;
        idx = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = TID_W'(i);
            end
        end
        return idx;
    endfunction

    assign tid_ok    = ({1'b0, tid_reg} < CNT_W'(THREAD_SLOTS));
    assign cmd_bit   = tid_ok ? (THREAD_SLOTS'(1) << tid_reg) : '0;
    assign pop       = pop_count(mask_reg);
    assign reached   = (pop == tgt_reg);
    assign wake_idx  = lowest_set(wake_reg);
    assign wake_rest = wake_reg & ~(THREAD_SLOTS'(1) << wake_idx);

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !ovalid_reg || out_ch.ready;

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.kind       = okind_reg;
    assign out_ch.thread_out = othread_reg;
    assign out_ch.last       = olast_reg;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        wake_next    = wake_reg;
        ctrl         = '0;
        emit         = 1'b0;
        okind_next   = okind_reg;
        othread_next = othread_reg;
        olast_next   = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                ctrl.look  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    othread_next = '0;
                    olast_next   = 1'b1;
                    state_next   = ST_IDLE;
                    if (cmd_reg == CMD_DEFINE)
                    begin
                        emit = 1'b1;
                        if (hit_any_reg)
                        begin
                            okind_next = KIND_ALREADY;
                        end
                        else if (free_any_reg)
                        begin
                            ctrl.wr_define = 1'b1;
                            okind_next     = KIND_DEFINED;
                        end
                        else
                        begin
                            okind_next = KIND_FULL;
                        end
                    end
                    else if (!hit_any_reg || !tid_ok)
                    begin
                        emit       = 1'b1;
                        okind_next = KIND_UNKNOWN;
                    end
                    else if (reached)
                    begin
                        // release: set goes empty, waiters drain from wake_reg
                        ctrl.wr_wait   = 1'b1;
                        ctrl.clear_set = 1'b1;
                        wake_next      = mask_reg;
                        state_next     = ST_WAKE;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        ctrl.wr_wait = 1'b1;
                        okind_next   = KIND_SLEEP;
                        othread_next = tid_reg;
                    end
                end
            end
            ST_WAKE:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    okind_next   = KIND_WAKE;
                    othread_next = wake_idx;
                    olast_next   = (wake_rest == '0);
                    wake_next    = wake_rest;
                    if (wake_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ovalid_next = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ovalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= cmd_t'(in_ch.cmd);
            tid_reg   <= in_ch.thread;
            addr_reg  <= in_ch.address;
            count_reg <= in_ch.thread_count;
        end
        if (ctrl.look)
        begin
            hit_any_reg  <= hit_c[BARRIER_SLOTS];
            free_any_reg <= free_c[BARRIER_SLOTS];
            mask_reg     <= mask_c[BARRIER_SLOTS];
            tgt_reg      <= target_c[BARRIER_SLOTS];
        end
        wake_reg    <= wake_next;
        okind_reg   <= okind_next;
        othread_reg <= othread_next;
        olast_reg   <= olast_next;
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // addresses are unique in the table, so at most one cell hits
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("more than one barrier matched");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAKE) |-> (wake_reg != '0))
        else $error("wake burst with empty waiter set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAKE && emit && olast_next) |=> (state_reg == ST_IDLE))
        else $error("wake burst did not end on last transaction");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for barrier_sync_unit: predictor, driver, monitor and stimulus.
module tb;
    import bsu_pkg::*;

    localparam int SLOTS       = DEF_BARRIER_SLOTS;
    localparam int THREADS     = DEF_THREAD_SLOTS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_OPS  = 310;
    localparam int HOLD_AFTER  = 60;   // long output hold-off once this many commands went in
    localparam int HOLD_CYCLES = 250;

    typedef struct {
        cmd_t        cmd;
        bit [5:0]    tid;
        bit [63:0]   addr;
        bit [6:0]    cnt;
    } barrier_op_t;

    typedef struct {
        kind_t       kind;
        bit [5:0]    thread;
        bit          last;
    } barrier_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bsu_in_if  in_ch();
    bsu_out_if out_ch();

    barrier_sync_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted barrier table, mirrors the unit's state
    bit        bar_valid   [SLOTS];
    bit [63:0] bar_addr    [SLOTS];
    bit [6:0]  bar_target  [SLOTS];
    bit [63:0] bar_waiters [SLOTS];

    barrier_op_t     op_queue[$];        // commands not yet offered to the unit
    barrier_result_t pending_results[$]; // predicted results, oldest first

    int  total_ops;
    int  ops_accepted;
    int  results_seen;
    int  kind_seen [6];
    int  releases;
    int  mismatches;
    int  cycles;
    int  src_gap;
    int  sink_gap;
    int  hold_left;
    bit  hold_fired;
    bit  in_fire;

    function automatic void push_result(kind_t kind, bit [5:0] thread, bit last);
        barrier_result_t res;
        res.kind   = kind;
        res.thread = thread;
        res.last   = last;
        pending_results.insert(pending_results.size(), res);
    endfunction

    // Applies one accepted command to the predicted table and queues its results.
    function automatic void barrier_apply(barrier_op_t op);
        int        hit;
        int        free_slot;
        bit [63:0] set;
        hit = -1;
        free_slot = -1;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (bar_valid[s] && bar_addr[s] == op.addr)
                hit = s;
            if (!bar_valid[s])
                free_slot = s;   // ends on the lowest free slot
        end
        if (op.cmd == CMD_DEFINE)
        begin
            if (hit >= 0)
                push_result(KIND_ALREADY, 6'd0, 1'b1);
            else if (free_slot >= 0)
            begin
                bar_valid[free_slot]   = 1'b1;
                bar_addr[free_slot]    = op.addr;
                bar_target[free_slot]  = op.cnt;
                bar_waiters[free_slot] = '0;
                push_result(KIND_DEFINED, 6'd0, 1'b1);
            end
            else
                push_result(KIND_FULL, 6'd0, 1'b1);
        end
        else if (hit < 0 || int'(op.tid) >= THREADS)
            push_result(KIND_UNKNOWN, 6'd0, 1'b1);
        else
        begin
            bar_waiters[hit][op.tid] = 1'b1;
            if ($countones(bar_waiters[hit]) == int'(bar_target[hit]))
            begin
                // release: wake every waiter, lowest thread first
                set = bar_waiters[hit];
                for (int t = 0; t < THREADS; t++)
                begin
                    if (set[t])
                    begin
                        set[t] = 1'b0;
                        push_result(KIND_WAKE, 6'(t), set == '0);
                    end
                end
                bar_waiters[hit] = '0;
            end
            else
                push_result(KIND_SLEEP, op.tid, 1'b1);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_define(bit [63:0] addr, bit [6:0] cnt);
        barrier_op_t op;
        op.cmd  = CMD_DEFINE;
        op.tid  = 6'($urandom);      // don't-care field, kept toggling
        op.addr = addr;
        op.cnt  = cnt;
        op_queue.insert(op_queue.size(), op);
    endtask

    task automatic push_wait(bit [63:0] addr, bit [5:0] tid);
        barrier_op_t op;
        op.cmd  = CMD_WAIT;
        op.tid  = tid;
        op.addr = addr;
        op.cnt  = 7'($urandom);      // don't-care field
        op_queue.insert(op_queue.size(), op);
    endtask

    task automatic flag_mismatch(string what, barrier_result_t exp_res);
        if (mismatches < 10)
            $display({"[%0d] %s: expected kind=%0d thread=%0d last=%0d, ",
                      "got kind=%0d thread=%0d last=%0d"},
                     cycles, what, exp_res.kind, exp_res.thread, exp_res.last,
                     out_ch.kind, out_ch.thread_out, out_ch.last);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input side. A transaction is taken at the rising edge; the prediction
    // is made right there, so the expected order follows the accept order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_fire <= in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            barrier_apply('{cmd_t'(in_ch.cmd), in_ch.thread, in_ch.address,
                            in_ch.thread_count});
            ops_accepted++;
        end
    end

    // Driver: new command (or a gap) at the falling edge once the current one
    // is gone. Every third block of 40 commands goes back to back.
    always @(negedge clk)
    begin
        barrier_op_t op;
        if (rst_n && (!in_ch.valid || in_fire))
        begin
            if (src_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (op_queue.size() != 0)
            begin
                op = op_queue[0];
                op_queue.delete(0);
                in_ch.cmd          <= op.cmd;
                in_ch.thread       <= op.tid;
                in_ch.address      <= op.addr;
                in_ch.thread_count <= op.cnt;
                in_ch.valid        <= 1'b1;
                src_gap <= (((total_ops - op_queue.size()) / 40) % 3 == 0) ? 0 : pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // One long hold-off: with ready low the output register fills, the
    // sequencer stalls and the input backs up while the driver keeps offering.
    always @(negedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_fired && ops_accepted >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
    end

    // Random receiver stalls, with a recurring stall-free stretch.
    always @(negedge clk)
    begin
        if (hold_left != 0 || (!hold_fired && ops_accepted >= HOLD_AFTER))
            out_ch.ready <= 1'b0;
        else if (sink_gap != 0)
        begin
            out_ch.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            sink_gap <= ((cycles / 256) % 4 == 0) ? 0 : pick_gap();
        end
    end

    // Monitor: every taken result against the oldest prediction.
    always @(posedge clk)
    begin
        barrier_result_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (out_ch.kind <= KIND_FULL)
                kind_seen[out_ch.kind]++;
            if (out_ch.kind == KIND_WAKE && out_ch.last)
                releases++;
            if (pending_results.size() == 0)
            begin
                exp_res = '{KIND_DEFINED, 6'd0, 1'b0};
                flag_mismatch("result with nothing expected", exp_res);
            end
            else
            begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                if (out_ch.kind !== exp_res.kind || out_ch.thread_out !== exp_res.thread ||
                    out_ch.last !== exp_res.last)
                    flag_mismatch("result mismatch", exp_res);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d commands taken, %0d results pending",
                     cycles, ops_accepted, total_ops, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stim
        bit [63:0] gen_addr [$];    // barriers in the table, in slot order
        int        gen_target [$];
        bit [63:0] addr_a, addr_b, addr_c, used;
        bit [5:0]  t;
        int        directed_ops, new_defs, r, idx, tgt;
        bit        big_done;

        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_DEFINE;
        in_ch.thread       = '0;
        in_ch.address      = '0;
        in_ch.thread_count = '0;
        out_ch.ready       = 1'b0;

        addr_a = 64'h8000_0000_0000_0001;
        addr_b = 64'h5555_AAAA_5555_AAAA;
        addr_c = 64'hFFFF_FFFF_0000_0000;

        // --- directed part ---
        push_wait('0, 6'd0);                 // unknown barrier on an empty table
        push_define('0, 7'd1);               // zero address, single-thread barrier
        push_define('0, 7'd5);               // duplicate define
        push_wait('0, 6'd63);                // immediate release of the top thread
        push_wait('0, 6'd0);                 // and of thread zero
        push_define('1, 7'd0);               // all-ones address, zero target never met
        push_wait('1, 6'd0);
        push_wait('1, 6'd0);                 // repeated wait
        push_define(addr_a, 7'd127);         // target beyond the thread count
        push_wait(addr_a, 6'd5);
        push_define(addr_b, 7'd3);
        push_wait(addr_b, 6'd63);
        push_wait(addr_b, 6'd63);            // repeat doesn't count twice
        push_define(addr_b, 7'd9);           // duplicate mid-round keeps the waiters
        push_wait(addr_b, 6'd0);
        push_wait(addr_b, 6'd31);            // release: wakes 0, 31, 63
        push_define(addr_c, 7'd64);          // needs every thread, done in the random part
        push_wait(addr_c, 6'd1);
        push_wait(64'h0123_4567_89AB_CDEF, 6'd42);
        directed_ops = op_queue.size();

        gen_addr   = '{64'd0, '1, addr_a, addr_b, addr_c};
        gen_target = '{1, 0, 127, 3, 64};
        new_defs   = 0;
        big_done   = 1'b0;

        // --- random part: mostly complete barrier rounds, some noise ---
        while (op_queue.size() - directed_ops < RANDOM_OPS)
        begin
            r = $urandom_range(0, 99);
            if (r < ((gen_addr.size() < SLOTS) ? 25 : 6))
            begin
                // new barrier; once all slots are taken this hits the full table
                if (gen_addr.size() < SLOTS)
                begin
                    tgt = (new_defs == 3) ? 0 :
                          (new_defs == 7) ? $urandom_range(65, 127) :
                          (new_defs == 9) ? 16 : $urandom_range(1, 8);
                    gen_addr.insert(gen_addr.size(), {$urandom, $urandom});
                    gen_target.insert(gen_target.size(), tgt);
                    push_define(gen_addr[$], 7'(tgt));
                    new_defs++;
                end
                else
                    push_define({$urandom, $urandom}, 7'($urandom));
            end
            else if (r < 32)
                push_define(gen_addr[$urandom_range(0, gen_addr.size() - 1)], 7'($urandom));
            else if (r < 38)
                push_wait({$urandom, $urandom}, 6'($urandom));
            else if (r < 42)
                push_wait(gen_addr[$urandom_range(0, gen_addr.size() - 1)], 6'($urandom));
            else
            begin
                // a round: exactly target distinct threads arrive
                if (!big_done && op_queue.size() - directed_ops >= 150)
                begin
                    idx = 4;             // the barrier that takes all threads
                    big_done = 1'b1;
                end
                else
                begin
                    do
                        idx = $urandom_range(0, gen_addr.size() - 1);
                    while (gen_target[idx] < 1 || gen_target[idx] > 16);
                end
                tgt  = gen_target[idx];
                used = '0;
                for (int k = 0; k < tgt; k++)
                begin
                    do
                        t = 6'($urandom);
                    while (used[t]);
                    used[t] = 1'b1;
                    push_wait(gen_addr[idx], t);
                    if (k < tgt - 1 && $urandom_range(0, 9) == 0)
                        push_wait(gen_addr[idx], t);
                    if (k < tgt - 1 && $urandom_range(0, 9) == 0)
                        push_define(gen_addr[idx], 7'($urandom));
                end
            end
        end
        total_ops = op_queue.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (ops_accepted != total_ops)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        // the result register must stay quiet once everything has drained
        repeat (10) @(posedge clk);

        $display("Covered %0d commands and %0d results: %0d defined, %0d duplicate, %0d full",
                 ops_accepted, results_seen, kind_seen[KIND_DEFINED], kind_seen[KIND_ALREADY],
                 kind_seen[KIND_FULL]);
        $display("  %0d sleeps, %0d wake-ups in %0d releases, %0d unknown; %0d mismatches",
                 kind_seen[KIND_SLEEP], kind_seen[KIND_WAKE], releases,
                 kind_seen[KIND_UNKNOWN], mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/bsu_pkg.sv
rtl/bsu_if.sv
rtl/bsu_cell.sv
rtl/barrier_sync_unit.sv
verif/tb.sv
